// File: design/fdb2_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdb2_pkg
// shared constants, types and the half kernel of the 2:1 decimation filter
// ----------------------------------------------------------------------------
package fdb2_pkg;

    localparam int TAPS_DEF        = 55;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF   = 18;
    localparam int HALF_LEN        = 28;
    localparam int COUNT_MAX       = 63;

    // half kernel scaled by 2^24, centre first
    localparam logic signed [24:0] HALF_KERNEL [HALF_LEN] = '{
        25'sd7456993, 25'sd5248851, 25'sd905790, -25'sd1514283, -25'sd831580,
        25'sd652504, 25'sd718026, -25'sd234598, -25'sd578542, -25'sd3512,
        25'sd428780, 25'sd134667, -25'sd284136, -25'sd191751, 25'sd157742,
        25'sd197317, -25'sd58147, -25'sd169438, -25'sd9169, 25'sd127748,
        25'sd51215, -25'sd74663, -25'sd50652, 25'sd68149, 25'sd111742,
        25'sd50500, -25'sd13962, -25'sd23146
    };

    // rounds a kernel value half away from zero to 25-coef_bits fewer bits
    function automatic logic signed [25:0] coef_at(input int offset, input int coef_bits);
        logic signed [25:0] h;
        logic        [25:0] mag;
        logic        [25:0] q;
        h   = 26'sd0;
        mag = '0;
        q   = '0;
        if (offset < HALF_LEN)
        begin
            h   = 26'(HALF_KERNEL[offset]);
            mag = h[25] ? 26'(-h) : 26'(h);
            q   = (((mag << 1) >> (25 - coef_bits)) + 26'd1) >> 1;
        end
        return h[25] ? -$signed(q) : $signed(q);
    endfunction

    // control carried from front to back with each queued entry
    typedef struct packed {
        logic emit;   // this shift completes an even centre
        logic last;   // final output of the run
        logic clear;  // end of run: clear the line after this shift
    } fdb2_ctl_t;

endpackage
`default_nettype wire

// File: design/fdb2_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdb2_front
// accepts samples, expands the last one into a zero flush, tags each shift
// ----------------------------------------------------------------------------
module fdb2_front #(
    parameter int TAPS        = fdb2_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = fdb2_pkg::SAMPLE_BITS_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire        [SAMPLE_BITS-1:0]   s_sample,
    input  wire                            s_last,
    output logic                           q_valid,
    input  wire                            q_ready,
    output logic       [SAMPLE_BITS-1:0]   q_sample,
    output fdb2_pkg::fdb2_ctl_t            q_ctl
);
    import fdb2_pkg::*;

    localparam int RADIUS = TAPS / 2;
    localparam int RW     = $clog2(RADIUS + 1);

    logic [5:0]    count_reg, count_next;
    logic          phase_reg, phase_next;
    logic [RW-1:0] flush_reg, flush_next;   // zero shifts still to issue
    logic          fire;
    logic          src_last;

    assign s_tready = (flush_reg == '0) && q_ready;
    assign q_valid  = (flush_reg != '0) || s_tvalid;
    assign q_sample = (flush_reg != '0) ? '0 : s_sample;
    assign fire     = q_valid && q_ready;
    assign src_last = (flush_reg != '0) ? (flush_reg == RW'(1)) : (s_last && RADIUS == 0);

    always_comb
    begin
        q_ctl.emit  = (count_reg >= 6'(RADIUS)) && (phase_reg == 1'(RADIUS & 1));
        // emitting shifts alternate, so the final output sits on one of the last two shifts
        q_ctl.last  = q_ctl.emit && ((flush_reg != '0) ? (int'(flush_reg) <= 2)
                                                        : (s_last && RADIUS <= 1));
        q_ctl.clear = src_last;
    end

    always_comb
    begin
        count_next = count_reg;
        phase_next = phase_reg;
        flush_next = flush_reg;
        if (fire)
        begin
            if (count_reg < 6'(COUNT_MAX))
                count_next = count_reg + 6'd1;
            phase_next = ~phase_reg;
            if (flush_reg != '0)
                flush_next = flush_reg - RW'(1);
            else if (s_last)
                flush_next = RW'(RADIUS);
            if (src_last)
            begin
                count_next = '0;
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            phase_reg <= 1'b0;
            flush_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            phase_reg <= phase_next;
            flush_reg <= flush_next;
        end
    end
endmodule
`default_nettype wire

// File: design/fdb2_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdb2_queue
// two-entry queue between the front and the filter
// ----------------------------------------------------------------------------
module fdb2_queue #(
    parameter int SAMPLE_BITS = fdb2_pkg::SAMPLE_BITS_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            i_valid,
    output logic                           i_ready,
    input  wire        [SAMPLE_BITS-1:0]   i_sample,
    input  fdb2_pkg::fdb2_ctl_t            i_ctl,
    output logic                           o_valid,
    input  wire                            o_ready,
    output logic       [SAMPLE_BITS-1:0]   o_sample,
    output fdb2_pkg::fdb2_ctl_t            o_ctl
);
    import fdb2_pkg::*;

    logic [SAMPLE_BITS-1:0] smp_reg [2];
    fdb2_ctl_t              ctl_reg [2];
    logic                   wp_reg, rp_reg;
    logic [1:0]             cnt_reg;
    logic                   push, pop;

    assign i_ready  = cnt_reg != 2'd2;
    assign o_valid  = cnt_reg != 2'd0;
    assign o_sample = smp_reg[rp_reg];
    assign o_ctl    = ctl_reg[rp_reg];
    assign push     = i_valid && i_ready;
    assign pop      = o_valid && o_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            smp_reg[wp_reg] <= i_sample;
            ctl_reg[wp_reg] <= i_ctl;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

// File: design/fdb2_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdb2_back
// delay line, symmetric pre-add, multipliers, registered adder tree, rounding
// ----------------------------------------------------------------------------
module fdb2_back #(
    parameter int TAPS        = fdb2_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = fdb2_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = fdb2_pkg::COEF_BITS_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            i_valid,
    output logic                           i_ready,
    input  wire        [SAMPLE_BITS-1:0]   i_sample,
    input  fdb2_pkg::fdb2_ctl_t            i_ctl,
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic       [SAMPLE_BITS-1:0]   m_sample,
    output logic                           m_last
);
    import fdb2_pkg::*;

    localparam int RADIUS = TAPS / 2;
    localparam int SPAN   = 2 * RADIUS + 1;
    localparam int NPROD  = RADIUS + 1;
    localparam int PW     = SAMPLE_BITS + 1 + COEF_BITS;
    localparam int AW     = PW + $clog2(NPROD) + 1;
    localparam int LEV    = $clog2(NPROD) + 1;
    localparam int NP2    = 1 << (LEV - 1);
    localparam int FRAC   = COEF_BITS - 1;
    // pipeline stages: pre-add (from the line view), product, tree levels, output reg; rounding is combinational
    localparam int DEPTH  = 2 + LEV + 1;

    logic signed [SAMPLE_BITS-1:0] line_reg [SPAN];
    logic signed [SAMPLE_BITS:0]   pre_reg  [NPROD];
    logic signed [PW-1:0]          prod_reg [NPROD];
    logic signed [AW-1:0]          tree_reg [LEV][NP2];
    logic [DEPTH-1:0]              v_reg;
    logic [DEPTH-1:0]              l_reg;
    logic                          adv;
    logic                          take;
    logic                          busy;
    logic signed [AW-1:0]          acc;
    logic        [AW-1:0]          mag;
    logic        [AW-1:0]          q;
    logic signed [AW-1:0]          r;
    logic signed [AW-1:0]          hi;
    logic signed [AW-1:0]          lo;

    // pipeline stalls as a whole when the output holds a result not taken
    assign adv     = !(m_tvalid && !m_tready);
    assign i_ready = adv;
    assign take    = i_valid && adv;
    assign busy    = v_reg[DEPTH-2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SPAN; i++)
                line_reg[i] <= '0;
        end
        else if (take)
        begin
            if (i_ctl.clear)
            begin
                for (int i = 0; i < SPAN; i++)
                    line_reg[i] <= '0;
            end
            else
            begin
                line_reg[0] <= $signed(i_sample);
                for (int i = 1; i < SPAN; i++)
                    line_reg[i] <= line_reg[i-1];
            end
        end
    end

    // the clearing shift still needs its filter view: snapshot pre-add from next line
    logic signed [SAMPLE_BITS-1:0] view [SPAN];
    always_comb
    begin
        view[0] = $signed(i_sample);
        for (int i = 1; i < SPAN; i++)
            view[i] = line_reg[i-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < NPROD; k++)
            begin
                if (k == 0)
                    pre_reg[k] <= (SAMPLE_BITS+1)'(view[RADIUS]);
                else
                    pre_reg[k] <= (SAMPLE_BITS+1)'(view[RADIUS-k])
                                + (SAMPLE_BITS+1)'(view[RADIUS+k]);
            end
            for (int k = 0; k < NPROD; k++)
                prod_reg[k] <= PW'(pre_reg[k] * COEF_BITS'(coef_at(k, COEF_BITS)));
            for (int j = 0; j < NPROD; j++)
                tree_reg[0][j] <= AW'(prod_reg[j]);
            for (int j = NPROD; j < NP2; j++)
                tree_reg[0][j] <= '0;
            for (int l = 1; l < LEV; l++)
                for (int j = 0; j < (NP2 >> l); j++)
                    tree_reg[l][j] <= tree_reg[l-1][2*j] + tree_reg[l-1][2*j+1];
        end
    end

    always_comb
    begin
        acc = tree_reg[LEV-1][0];
        mag = acc[AW-1] ? AW'(-acc) : AW'(acc);
        q   = (mag + (AW'(1) << (FRAC - 1))) >> FRAC;
        r   = acc[AW-1] ? -$signed(q) : $signed(q);
        hi  = AW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
        lo  = -hi - AW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (adv && busy)
            m_sample <= (r > hi) ? SAMPLE_BITS'(hi) :
                        (r < lo) ? SAMPLE_BITS'(lo) : SAMPLE_BITS'(r);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
            l_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[DEPTH-2:0], take && i_ctl.emit};
            l_reg <= {l_reg[DEPTH-2:0], take && i_ctl.last};
        end
    end

    assign m_tvalid = v_reg[DEPTH-1];
    assign m_last   = l_reg[DEPTH-1];
endmodule
`default_nettype wire

// File: design/fir_decimate_by_two.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fir_decimate_by_two
// symmetric low-pass fir with 2:1 decimation and end-of-run zero flush
// ----------------------------------------------------------------------------
// channel   dir  tdata                  tuser
// s_axis    in   [23:0] in_sample       -      (tlast = in_last)
// m_axis    out  [23:0] out_sample      -      (tlast = out_last)
//
// one sample per clock while s_tready is high; a last sample adds TAPS/2 zero flush shifts with s_tready low
// a result passes the pre-add, product, adder tree and output registers after its completing shift is accepted
// the filter pipeline holds whenever m_tready is low with a result waiting
// reset clears the delay line, run count and flush counter at once
// ----------------------------------------------------------------------------
module fir_decimate_by_two #(
    parameter int TAPS        = fdb2_pkg::TAPS_DEF,
    parameter int SAMPLE_BITS = fdb2_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS   = fdb2_pkg::COEF_BITS_DEF
) (
    input  wire                                          clk,
    input  wire                                          rst_n,
    input  wire                                          s_axis_tvalid,
    output logic                                         s_axis_tready,
    input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]             s_axis_tdata,  // in_sample
    input  wire                                          s_axis_tlast,
    output logic                                         m_axis_tvalid,
    input  wire                                          m_axis_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]             m_axis_tdata,  // out_sample
    output logic                                         m_axis_tlast
);
    import fdb2_pkg::*;

    localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;

    logic                   f_valid, f_ready, b_valid, b_ready;
    logic [SAMPLE_BITS-1:0] f_sample, b_sample, o_sample;
    fdb2_ctl_t              f_ctl, b_ctl;

    fdb2_front #(.TAPS(TAPS), .SAMPLE_BITS(SAMPLE_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready),
        .s_sample(s_axis_tdata[SAMPLE_BITS-1:0]), .s_last(s_axis_tlast),
        .q_valid(f_valid), .q_ready(f_ready), .q_sample(f_sample), .q_ctl(f_ctl)
    );

    fdb2_queue #(.SAMPLE_BITS(SAMPLE_BITS)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .i_valid(f_valid), .i_ready(f_ready), .i_sample(f_sample), .i_ctl(f_ctl),
        .o_valid(b_valid), .o_ready(b_ready), .o_sample(b_sample), .o_ctl(b_ctl)
    );

    fdb2_back #(.TAPS(TAPS), .SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .i_valid(b_valid), .i_ready(b_ready), .i_sample(b_sample), .i_ctl(b_ctl),
        .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready),
        .m_sample(o_sample), .m_last(m_axis_tlast)
    );

    // pad bits above the sample are zero
    assign m_axis_tdata = DW'(o_sample);
endmodule
`default_nettype wire

// File: design/fdb2_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdb2_checker
// port-level checks of the decimating filter
// ----------------------------------------------------------------------------
module fdb2_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        s_axis_tlast,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata,
    input wire        m_axis_tlast
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tlast))
        else $error("output transaction dropped");

    a_flush: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input taken during flush");

    a_reset: assert property (@(posedge clk)
        !rst_n |-> !m_axis_tvalid)
        else $error("output valid in reset");
endmodule

bind fir_decimate_by_two fdb2_checker u_fdb2_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tlast(s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata[23:0]), .m_axis_tlast(m_axis_tlast)
);
`default_nettype wire

// File: sim/fir_decimate_by_two_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_decimate_by_two_checker
// predicts the decimated filter outputs from accepted input transactions and
// compares every output transaction against the oldest predicted sample
// ----------------------------------------------------------------------------
module fir_decimate_by_two_checker (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    input  wire        s_axis_tready,
    input  wire [23:0] s_axis_tdata,   // in_sample
    input  wire        s_axis_tlast,
    input  wire        m_axis_tvalid,
    input  wire        m_axis_tready,
    input  wire [23:0] m_axis_tdata,   // out_sample
    input  wire        m_axis_tlast,
    output int         mismatches,
    output int         pending
);
    localparam int RADIUS = fdb2_pkg::TAPS_DEF / 2;
    localparam int SPAN   = 2 * RADIUS + 1;
    localparam int FRAC   = fdb2_pkg::COEF_BITS_DEF - 1;

    typedef struct packed {
        logic [23:0] sample;
        logic        last;
    } filt_out_t;

    longint    taps_q [SPAN];
    longint    line [SPAN];
    int        run_count;
    bit        odd_phase;
    filt_out_t expected_q [$];

    function automatic longint quant_coef(int offset);
        longint h;
        longint mag;
        longint q;
        if (offset >= fdb2_pkg::HALF_LEN)
            return 0;
        h   = longint'(fdb2_pkg::HALF_KERNEL[offset]);
        mag = h < 0 ? -h : h;
        q   = (((mag << 1) >>> (25 - fdb2_pkg::COEF_BITS_DEF)) + 1) >>> 1;
        return h < 0 ? -q : q;
    endfunction

    function automatic logic [23:0] centre_value();
        longint acc;
        longint mag;
        longint r;
        acc = 0;
        for (int i = 0; i < SPAN; i++)
            acc += taps_q[i] * line[i];
        mag = acc < 0 ? -acc : acc;
        r   = (mag + (longint'(1) << (FRAC - 1))) >>> FRAC;
        if (acc < 0)
            r = -r;
        if (r > 8388607)
            r = 8388607;
        if (r < -8388608)
            r = -8388608;
        return r[23:0];
    endfunction

    task automatic shift_in(longint x);
        filt_out_t item;
        for (int i = SPAN - 1; i > 0; i--)
            line[i] = line[i-1];
        line[0] = x;
        if (run_count >= RADIUS && odd_phase == RADIUS[0])
        begin
            item.sample = centre_value();
            item.last   = 1'b0;
            expected_q.insert(expected_q.size(), item);
        end
        if (run_count < fdb2_pkg::COUNT_MAX)
            run_count++;
        odd_phase = ~odd_phase;
    endtask

    task automatic clear_run();
        foreach (line[i])
            line[i] = 0;
        run_count = 0;
        odd_phase = 0;
    endtask

    initial
    begin
        for (int i = 0; i < SPAN; i++)
            taps_q[i] = quant_coef(i <= RADIUS ? RADIUS - i : i - RADIUS);
        clear_run();
        mismatches = 0;
        pending    = 0;
    end

    always @(posedge clk)
    begin
        filt_out_t exp_item;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output: data=%h last=%b",
                                 m_axis_tdata, m_axis_tlast);
                end
                else
                begin
                    exp_item = expected_q.pop_front();
                    if (m_axis_tdata !== exp_item.sample || m_axis_tlast !== exp_item.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("output mismatch: expected %h/%b, got %h/%b",
                                     exp_item.sample, exp_item.last,
                                     m_axis_tdata, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                shift_in(longint'($signed(s_axis_tdata)));
                if (s_axis_tlast)
                begin
                    for (int k = 0; k < RADIUS; k++)
                        shift_in(0);
                    // final output of the run carries last
                    expected_q[expected_q.size()-1].last = 1'b1;
                    clear_run();
                end
            end
        end
        pending <= expected_q.size();
    end
endmodule

// File: sim/fir_decimate_by_two_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_decimate_by_two_tb
// drives runs of audio samples with random idling on both channels and
// reports the verdict from the checker's mismatch count
// ----------------------------------------------------------------------------
module fir_decimate_by_two_tb;
    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;
    int          mismatches;
    int          pending;
    bit          quiet;

    fir_decimate_by_two uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    fir_decimate_by_two_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .mismatches(mismatches), .pending(pending)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    // receiver stalls in bursts
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (quiet || $urandom_range(0, 7) != 0)
                m_axis_tready <= 1'b1;
            else
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_sample(logic [23:0] value, logic is_last);
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= is_last;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    function automatic logic [23:0] rand_sample();
        case ($urandom_range(0, 4))
            0:       return 24'h7fffff;
            1:       return 24'h800000;
            default: return 24'($urandom);
        endcase
    endfunction

    initial
    begin
        int len;
        int sent;
        quiet         = 0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single-sample runs at both extremes and zero, a short run, then a full-scale run
        send_sample(24'h7fffff, 1'b1);
        send_sample(24'h800000, 1'b1);
        send_sample(24'h000000, 1'b1);
        send_sample(24'h000001, 1'b0);
        send_sample(24'hffffff, 1'b1);
        for (int i = 0; i < 18; i++)
            send_sample(i[0] ? 24'h800000 : 24'h7fffff, i == 17);

        // random runs of mixed length, some past the count saturation
        sent = 0;
        while (sent < 230)
        begin
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 80)
                                              : $urandom_range(1, 40);
            if (sent > 170)
                quiet = 1;
            for (int i = 0; i < len; i++)
                send_sample(rand_sample(), i == len - 1);
            sent += len;
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        // let the predictor count settle past the final input transaction
        repeat (2) @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
